>>> src/rv32x_pkg.sv
// Shared constants, opcodes, types and helpers for the RV32 execute unit.
`default_nettype none

package rv32x_pkg;

  // Architectural sizes
  localparam int NUM_REGS = 32;
  localparam int REG_AW   = $clog2(NUM_REGS);

  localparam logic [31:0] PC_STEP     = 32'd4;
  localparam int          UPPER_SHIFT = 12;

  // Decoded opcode numbers
  localparam logic [5:0] OP_UNIMPL      = 6'd0;
  localparam logic [5:0] OP_ADD         = 6'd1;
  localparam logic [5:0] OP_AND         = 6'd2;
  localparam logic [5:0] OP_OR          = 6'd3;
  localparam logic [5:0] OP_XOR         = 6'd4;
  localparam logic [5:0] OP_SUB         = 6'd5;
  localparam logic [5:0] OP_SLL         = 6'd6;
  localparam logic [5:0] OP_SRL         = 6'd7;
  localparam logic [5:0] OP_SRA         = 6'd8;
  localparam logic [5:0] OP_SLT         = 6'd9;
  localparam logic [5:0] OP_SLTU        = 6'd10;
  localparam logic [5:0] OP_ADDI        = 6'd11;
  localparam logic [5:0] OP_ANDI        = 6'd12;
  localparam logic [5:0] OP_ORI         = 6'd13;
  localparam logic [5:0] OP_XORI        = 6'd14;
  localparam logic [5:0] OP_SLLI        = 6'd15;
  localparam logic [5:0] OP_SRLI        = 6'd16;
  localparam logic [5:0] OP_SRAI        = 6'd17;
  localparam logic [5:0] OP_SLTI        = 6'd18;
  localparam logic [5:0] OP_SLTIU       = 6'd19;
  localparam logic [5:0] OP_LOAD_FIRST  = 6'd20;
  localparam logic [5:0] OP_LOAD_LAST   = 6'd24;
  localparam logic [5:0] OP_STORE_FIRST = 6'd25;
  localparam logic [5:0] OP_STORE_LAST  = 6'd27;
  localparam logic [5:0] OP_BEQ         = 6'd28;
  localparam logic [5:0] OP_BNE         = 6'd29;
  localparam logic [5:0] OP_BGE         = 6'd30;
  localparam logic [5:0] OP_BGEU        = 6'd31;
  localparam logic [5:0] OP_BLT         = 6'd32;
  localparam logic [5:0] OP_BLTU        = 6'd33;
  localparam logic [5:0] OP_JAL         = 6'd34;
  localparam logic [5:0] OP_JALR        = 6'd35;
  localparam logic [5:0] OP_AUIPC       = 6'd36;
  localparam logic [5:0] OP_LUI         = 6'd37;
  localparam logic [5:0] OP_CUST_FIRST  = 6'd38;
  localparam logic [5:0] OP_CUST_LAST   = 6'd45;
  localparam logic [5:0] OP_HCF         = 6'd46;

  typedef enum logic [1:0] {
    EXT_NONE   = 2'd0,
    EXT_READ   = 2'd1,
    EXT_WRITE  = 2'd2,
    EXT_CUSTOM = 2'd3
  } ext_kind_t;

  typedef enum logic {
    REQ_EXEC   = 1'b0,
    REQ_RETURN = 1'b1
  } req_type_t;

  // One input word as held in the execute stage
  typedef struct packed {
    req_type_t   req_type;
    logic [5:0]  opcode;
    logic [4:0]  rd;
    logic [4:0]  rs1;
    logic [4:0]  rs2;
    logic [31:0] imm;
    logic [31:0] ret_data;
  } item_t;

  // Architectural state other than the register file
  typedef struct packed {
    logic [31:0] pc;
    logic        pending;
    logic [4:0]  pdest;
    logic        halt;
  } arch_state_t;

  // Register file write
  typedef struct packed {
    logic        en;
    logic [4:0]  idx;
    logic [31:0] val;
  } reg_wr_t;

  // One result word
  typedef struct packed {
    logic [31:0] pc_now;
    ext_kind_t   ext_kind;
    logic [5:0]  ext_op;
    logic [31:0] ext_a;
    logic [31:0] ext_d;
    reg_wr_t     wr;
    logic        halted;
    logic        perr;
  } result_t;

  // x0 and indexes past the implemented file read as zero and drop writes
  function automatic logic reg_idx_ok(logic [4:0] idx);
    return (idx != '0) && (32'(idx) < NUM_REGS);
  endfunction

endpackage

`default_nettype wire

>>> src/rv32x_regfile.sv
// Register file: two storage copies for three read ports, valid bits and write bypass.
`default_nettype none

module rv32x_regfile import rv32x_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        rd_en,
  input  wire logic [4:0]  rd_idx_s,
  input  wire logic [4:0]  rd_idx_a,
  input  wire logic [4:0]  rd_idx_b,
  input  wire reg_wr_t     wr,
  output logic      [31:0] val_s,
  output logic      [31:0] val_a,
  output logic      [31:0] val_b
);

  // Copy one serves rs1/rs2, copy two serves the rd/source-data port
  logic [31:0] mem_ab [NUM_REGS];
  logic [31:0] mem_s  [NUM_REGS];
  logic [NUM_REGS-1:0] valid_r;

  logic [31:0] dat_s_r, dat_a_r, dat_b_r;
  logic        ok_s_r, ok_a_r, ok_b_r;
  logic [4:0]  idx_s_r, idx_a_r, idx_b_r;

  // Last write, bypassed to the word read in the same edge
  logic        lw_en_r;
  logic [4:0]  lw_idx_r;
  logic [31:0] lw_val_r;

  // Storage writes and registered reads
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem_ab[wr.idx[REG_AW-1:0]] <= wr.val;
      mem_s[wr.idx[REG_AW-1:0]]  <= wr.val;
    end
    if (rd_en) begin
      dat_s_r <= mem_s[rd_idx_s[REG_AW-1:0]];
      dat_a_r <= mem_ab[rd_idx_a[REG_AW-1:0]];
      dat_b_r <= mem_ab[rd_idx_b[REG_AW-1:0]];
    end
  end

  // Read tags: index and whether the entry holds written data
  always_ff @(posedge clk) begin
    if (rd_en) begin
      idx_s_r <= rd_idx_s;
      idx_a_r <= rd_idx_a;
      idx_b_r <= rd_idx_b;
      ok_s_r  <= reg_idx_ok(rd_idx_s) && valid_r[rd_idx_s[REG_AW-1:0]];
      ok_a_r  <= reg_idx_ok(rd_idx_a) && valid_r[rd_idx_a[REG_AW-1:0]];
      ok_b_r  <= reg_idx_ok(rd_idx_b) && valid_r[rd_idx_b[REG_AW-1:0]];
    end
    if (wr.en) begin
      lw_idx_r <= wr.idx;
      lw_val_r <= wr.val;
    end
  end

  // Valid bits and bypass enable
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      lw_en_r <= 1'b0;
    end else if (wr.en) begin
      valid_r[wr.idx[REG_AW-1:0]] <= 1'b1;
      lw_en_r <= 1'b1;
    end
  end

  // Read values: bypass wins, then stored data, else zero
  always_comb begin
    val_s = ok_s_r ? dat_s_r : '0;
    val_a = ok_a_r ? dat_a_r : '0;
    val_b = ok_b_r ? dat_b_r : '0;
    if (lw_en_r && (lw_idx_r == idx_s_r)) val_s = lw_val_r;
    if (lw_en_r && (lw_idx_r == idx_a_r)) val_a = lw_val_r;
    if (lw_en_r && (lw_idx_r == idx_b_r)) val_b = lw_val_r;
  end

  // Writes only reach real registers
  a_wr_idx_ok: assert property (@(posedge clk) disable iff (!rst_n)
    wr.en |-> reg_idx_ok(wr.idx))
    else $error("register write to x0 or unimplemented index");

  // A written entry is valid afterwards
  a_valid_set: assert property (@(posedge clk) disable iff (!rst_n)
    wr.en |=> valid_r[$past(wr.idx[REG_AW-1:0])])
    else $error("valid bit not set after write");

  // Bypass register follows the write
  a_bypass: assert property (@(posedge clk) disable iff (!rst_n)
    wr.en |=> (lw_en_r && lw_val_r == $past(wr.val) && lw_idx_r == $past(wr.idx)))
    else $error("bypass register out of step with write");

endmodule

`default_nettype wire

>>> src/rv32x_exec.sv
// Execute logic: one decoded instruction or return word against the current state.
`default_nettype none

module rv32x_exec import rv32x_pkg::*; (
  input  wire item_t       item,
  input  wire arch_state_t cur,
  input  wire logic [31:0] val_s,
  input  wire logic [31:0] val_a,
  input  wire logic [31:0] val_b,
  output result_t          res,
  output arch_state_t      nxt
);

  logic [31:0] pc_plus4;
  logic [31:0] upper_imm;
  logic [31:0] val;
  logic        do_wr;
  logic [5:0]  op;

  assign pc_plus4  = cur.pc + PC_STEP;
  assign upper_imm = item.imm << UPPER_SHIFT;
  assign op        = item.opcode;

  // Return write, or an instruction's result value, branch/jump target, request
  always_comb begin
    val      = '0;
    do_wr    = 1'b0;
    nxt      = cur;
    res      = '0;
    res.ext_kind = EXT_NONE;

    priority if (item.req_type == REQ_RETURN) begin
      if (!cur.pending) begin
        res.perr = 1'b1;
      end else begin
        res.wr.en   = reg_idx_ok(cur.pdest);
        res.wr.idx  = cur.pdest;
        res.wr.val  = item.ret_data;
        nxt.pending = 1'b0;
        nxt.pc      = pc_plus4;
      end
    end else if (cur.pending) begin
      res.perr = 1'b1;
    end else if (cur.halt) begin
      // halted core ignores instructions
    end else begin
      nxt.pc  = pc_plus4;
      unique case (op)
        OP_ADD:   begin val = val_a + val_b;                               do_wr = 1'b1; end
        OP_SUB:   begin val = val_a - val_b;                               do_wr = 1'b1; end
        OP_AND:   begin val = val_a & val_b;                               do_wr = 1'b1; end
        OP_OR:    begin val = val_a | val_b;                               do_wr = 1'b1; end
        OP_XOR:   begin val = val_a ^ val_b;                               do_wr = 1'b1; end
        OP_SLL:   begin val = val_a << val_b[4:0];                         do_wr = 1'b1; end
        OP_SRL:   begin val = val_a >> val_b[4:0];                         do_wr = 1'b1; end
        OP_SRA:   begin val = 32'($signed(val_a) >>> val_b[4:0]);          do_wr = 1'b1; end
        OP_SLT:   begin val = {31'd0, $signed(val_a) < $signed(val_b)};    do_wr = 1'b1; end
        OP_SLTU:  begin val = {31'd0, val_a < val_b};                      do_wr = 1'b1; end
        OP_ADDI:  begin val = val_a + item.imm;                            do_wr = 1'b1; end
        OP_ANDI:  begin val = val_a & item.imm;                            do_wr = 1'b1; end
        OP_ORI:   begin val = val_a | item.imm;                            do_wr = 1'b1; end
        OP_XORI:  begin val = val_a ^ item.imm;                            do_wr = 1'b1; end
        OP_SLLI:  begin val = val_a << item.imm[4:0];                      do_wr = 1'b1; end
        OP_SRLI:  begin val = val_a >> item.imm[4:0];                      do_wr = 1'b1; end
        OP_SRAI:  begin val = 32'($signed(val_a) >>> item.imm[4:0]);       do_wr = 1'b1; end
        OP_SLTI:  begin val = {31'd0, $signed(val_a) < $signed(item.imm)}; do_wr = 1'b1; end
        OP_SLTIU: begin val = {31'd0, val_a < item.imm};                   do_wr = 1'b1; end
        OP_BEQ:   if (val_s == val_a) nxt.pc = item.imm;
        OP_BNE:   if (val_s != val_a) nxt.pc = item.imm;
        OP_BGE:   if (!($signed(val_s) < $signed(val_a))) nxt.pc = item.imm;
        OP_BGEU:  if (val_s >= val_a) nxt.pc = item.imm;
        OP_BLT:   if ($signed(val_s) < $signed(val_a)) nxt.pc = item.imm;
        OP_BLTU:  if (val_s < val_a) nxt.pc = item.imm;
        OP_JAL: begin
          val    = pc_plus4;
          do_wr  = 1'b1;
          nxt.pc = item.imm;
        end
        OP_JALR: begin
          val    = pc_plus4;
          do_wr  = 1'b1;
          nxt.pc = (val_a + item.imm) & ~32'd1;
        end
        OP_AUIPC: begin val = cur.pc + upper_imm; do_wr = 1'b1; end
        OP_LUI:   begin val = upper_imm;          do_wr = 1'b1; end
        OP_HCF:   nxt.halt = 1'b1;
        default: begin
          priority if (op >= OP_LOAD_FIRST && op <= OP_LOAD_LAST) begin
            res.ext_kind = EXT_READ;
            res.ext_op   = op;
            res.ext_a    = val_a + item.imm;
            nxt.pending  = 1'b1;
            nxt.pdest    = item.rd;
            nxt.pc       = cur.pc;
          end else if (op >= OP_STORE_FIRST && op <= OP_STORE_LAST) begin
            res.ext_kind = EXT_WRITE;
            res.ext_op   = op;
            res.ext_a    = val_a + item.imm;
            res.ext_d    = val_s;
          end else if (op >= OP_CUST_FIRST && op <= OP_CUST_LAST) begin
            res.ext_kind = EXT_CUSTOM;
            res.ext_op   = op;
            res.ext_a    = val_a;
            res.ext_d    = val_b;
            nxt.pending  = 1'b1;
            nxt.pdest    = item.rd;
            nxt.pc       = cur.pc;
          end else begin
            // unimplemented: pc advance only
          end
        end
      endcase
      res.wr.en  = do_wr && reg_idx_ok(item.rd);
      res.wr.idx = item.rd;
      res.wr.val = val;
    end

    // Unused write fields read as zero
    if (!res.wr.en) begin
      res.wr.idx = '0;
      res.wr.val = '0;
    end
    res.pc_now = nxt.pc;
    res.halted = nxt.halt;
  end

endmodule

`default_nettype wire

>>> src/rv32im_execute_unit.sv
// Top level: input stage, execute logic, architectural state and result register.
//
// Usage
//   Input channel (in_valid/in_ready): one word is either a decoded instruction
//   (in_req_type 0) or the data returning for an outstanding load or custom op
//   (in_req_type 1). Result channel (out_valid/out_ready): exactly one result
//   word per input word, in order, carrying the new pc, any external request,
//   the register write made, the halt flag and a protocol error flag.
//   An accepted word is held in the input register while the register file is
//   read, then its result is held in the result register. Throughput: one word
//   per cycle while out_ready is high; the register file write of one word is
//   bypassed to the word behind it, so dependent instructions issue back to
//   back.
//   Stall: when out_ready is low the result register holds; the input register
//   still takes one more word, then in_ready drops until the result drains.
//   Reset (rst_n low, synchronous): pc, pending return, pending destination,
//   halt flag and all register valid bits clear, so every register reads zero.
//   No clearing pass is needed; the block takes words right after reset.
`default_nettype none

module rv32im_execute_unit import rv32x_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  // input channel
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic               in_req_type,
  input  wire logic        [5:0]  in_opcode,
  input  wire logic        [4:0]  in_dest_or_src_reg,
  input  wire logic        [4:0]  in_src_reg_a,
  input  wire logic        [4:0]  in_src_reg_b,
  input  wire logic signed [31:0] in_immediate,
  input  wire logic        [31:0] in_return_data,
  // result channel
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic             [31:0] out_pc_now,
  output logic             [1:0]  out_ext_kind,
  output logic             [5:0]  out_ext_op,
  output logic             [31:0] out_ext_addr_or_a,
  output logic             [31:0] out_ext_data_or_b,
  output logic                    out_write_enable,
  output logic             [4:0]  out_write_index,
  output logic             [31:0] out_write_value,
  output logic                    out_halted,
  output logic                    out_protocol_error
);

  logic        in_accept;
  logic        fire;
  logic        s1_valid_r;
  item_t       item_r;
  arch_state_t state_r;
  arch_state_t state_nxt;
  result_t     res;
  result_t     out_r;
  logic        out_valid_r;
  reg_wr_t     rf_wr;
  logic [31:0] val_s, val_a, val_b;

  // Handshake: execute stage fires when the result register is free or draining
  assign fire      = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !s1_valid_r || fire;
  assign in_accept = in_valid && in_ready;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_accept) begin
      s1_valid_r <= 1'b1;
    end else if (fire) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      item_r.req_type <= req_type_t'(in_req_type);
      item_r.opcode   <= in_opcode;
      item_r.rd       <= in_dest_or_src_reg;
      item_r.rs1      <= in_src_reg_a;
      item_r.rs2      <= in_src_reg_b;
      item_r.imm      <= 32'(in_immediate);
      item_r.ret_data <= in_return_data;
    end
  end

  // Register file is read with the incoming word's indexes
  assign rf_wr.en  = fire && res.wr.en;
  assign rf_wr.idx = res.wr.idx;
  assign rf_wr.val = res.wr.val;

  rv32x_regfile u_regfile (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_en    (in_accept),
    .rd_idx_s (in_dest_or_src_reg),
    .rd_idx_a (in_src_reg_a),
    .rd_idx_b (in_src_reg_b),
    .wr       (rf_wr),
    .val_s    (val_s),
    .val_a    (val_a),
    .val_b    (val_b)
  );

  rv32x_exec u_exec (
    .item  (item_r),
    .cur   (state_r),
    .val_s (val_s),
    .val_a (val_a),
    .val_b (val_b),
    .res   (res),
    .nxt   (state_nxt)
  );

  // Architectural state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else if (fire) begin
      state_r <= state_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_r <= res;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_pc_now         = out_r.pc_now;
  assign out_ext_kind       = out_r.ext_kind;
  assign out_ext_op         = out_r.ext_op;
  assign out_ext_addr_or_a  = out_r.ext_a;
  assign out_ext_data_or_b  = out_r.ext_d;
  assign out_write_enable   = out_r.wr.en;
  assign out_write_index    = out_r.wr.idx;
  assign out_write_value    = out_r.wr.val;
  assign out_halted         = out_r.halted;
  assign out_protocol_error = out_r.perr;

  // A rejected word never writes a register
  a_err_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_protocol_error && out_write_enable))
    else $error("protocol error with register write");

  // No external request means no request fields
  a_ext_none: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ext_kind == EXT_NONE) |->
      (out_ext_op == '0 && out_ext_addr_or_a == '0 && out_ext_data_or_b == '0))
    else $error("request fields set without request");

  // Halt is sticky
  a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.halt |=> state_r.halt)
    else $error("halt flag cleared");

  // A pending return only starts with a read or custom request
  a_pending_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(state_r.pending) |->
      (out_ext_kind == EXT_READ || out_ext_kind == EXT_CUSTOM))
    else $error("return pending without a read or custom request");

  // A result word follows every execute-stage firing
  a_fire_out: assert property (@(posedge clk) disable iff (!rst_n)
    fire |=> out_valid)
    else $error("fired word produced no result");

endmodule

`default_nettype wire
